[hdl/lru_byte_budget_evictor_assert.svh]
// ----------------------------------------------------------------------------
// lru_byte_budget_evictor_assert.svh
// Assertion macros shared by the evictor RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_BYTE_BUDGET_EVICTOR_ASSERT_SVH
`define LRU_BYTE_BUDGET_EVICTOR_ASSERT_SVH

// same-cycle implication
`define LBBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbbe: same-cycle check failed");

// next-cycle implication
`define LBBE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbbe: next-cycle check failed");

`endif

[hdl/lbbe_pkg.sv]
// ----------------------------------------------------------------------------
// lbbe_pkg
// Types, codes and constants of the LRU byte-budget evictor.
// ----------------------------------------------------------------------------
`default_nettype none

package lbbe_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int OP_W      = 3;
    localparam int SLOT_W    = 4;
    localparam int BYTES_W   = 40;
    localparam int TOTAL_W   = 44;
    localparam int STAMP_W   = 48;
    localparam int PIN_W     = 16;
    localparam int STATUS_W  = 3;
    localparam int EVICT_CAP = 16;
    localparam int EVCNT_W   = 5;

    localparam logic [BYTES_W-1:0] BUDGET_RESET = 40'd536870912;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;
    localparam logic [STAMP_W-1:0] STAMP_MAX    = '1;
    localparam logic [PIN_W-1:0]   PIN_MAX      = '1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_TOUCH    = 3'd1,
        OP_RESIZE   = 3'd2,
        OP_PIN      = 3'd3,
        OP_UNPIN    = 3'd4,
        OP_REMOVE   = 3'd5,
        OP_SET_HELD = 3'd6,
        OP_TRIM     = 3'd7
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_ABSENT        = 3'd1,
        ST_OCCUPIED      = 3'd2,
        ST_PIN_OVERFLOW  = 3'd3,
        ST_PIN_UNDERFLOW = 3'd4,
        ST_ZERO_BYTES    = 3'd5
    } t_status;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_EVICT  = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_RESOLVE,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic [BYTES_W-1:0] bytes;
        logic [STAMP_W-1:0] stamp;
        logic [PIN_W-1:0]   pins;
        logic               held;
    } t_entry;

    typedef struct packed {
        t_kind              kind;
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [TOTAL_W-1:0] total;
    } t_result;

    typedef struct packed {
        logic clear;
        logic sample;
    } t_scan_ctl;

endpackage

`default_nettype wire

[hdl/lbbe_if.sv]
// ----------------------------------------------------------------------------
// lbbe_if
// Valid/ready channels of the evictor: operation in, results out, budget.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbbe_in_if;
    logic                            valid;
    logic                            ready;
    logic [lbbe_pkg::OP_W-1:0]       op;
    logic [lbbe_pkg::SLOT_W-1:0]     slot;
    logic [lbbe_pkg::BYTES_W-1:0]    byte_size;
    logic                            held_outside;

    modport source (output valid, op, slot, byte_size, held_outside, input ready);
    modport sink   (input valid, op, slot, byte_size, held_outside, output ready);
endinterface

interface lbbe_out_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [lbbe_pkg::STATUS_W-1:0]   status;
    logic [lbbe_pkg::SLOT_W-1:0]     result_slot;
    logic [lbbe_pkg::TOTAL_W-1:0]    resident_total;
    logic                            last;

    modport source (output valid, kind, status, result_slot, resident_total, last,
                    input ready);
    modport sink   (input valid, kind, status, result_slot, resident_total, last,
                    output ready);
endinterface

interface lbbe_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lbbe_pkg::BYTES_W-1:0]    byte_budget;

    modport source (output valid, byte_budget, input ready);
    modport sink   (input valid, byte_budget, output ready);
endinterface

`default_nettype wire

[hdl/lbbe_oldest.sv]
// ----------------------------------------------------------------------------
// lbbe_oldest
// Compare unit: takes one table entry per cycle and keeps the oldest
// evictable one (unpinned, not held); first seen wins on equal stamps.
// ----------------------------------------------------------------------------
`default_nettype none

module lbbe_oldest #(
    parameter int SLOTS = lbbe_pkg::SLOTS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire lbbe_pkg::t_scan_ctl           i_ctl,
    input  wire lbbe_pkg::t_entry              i_entry,
    input  wire                                i_entry_valid,
    input  wire [$clog2(SLOTS)-1:0]            i_idx,
    output logic                               o_found,
    output logic [$clog2(SLOTS)-1:0]           o_idx,
    output logic [lbbe_pkg::BYTES_W-1:0]       o_bytes
);

    localparam int IW = $clog2(SLOTS);

    logic                          r_found;
    logic [IW-1:0]                 r_idx;
    logic [lbbe_pkg::STAMP_W-1:0]  r_stamp;
    logic [lbbe_pkg::BYTES_W-1:0]  r_bytes;
    logic                          eligible;
    logic                          take;

    assign eligible = i_entry_valid && (i_entry.pins == '0) && !i_entry.held;
    assign take     = i_ctl.sample && eligible && (!r_found || (i_entry.stamp < r_stamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !i_ctl.clear) begin
            r_idx   <= i_idx;
            r_stamp <= i_entry.stamp;
            r_bytes <= i_entry.bytes;
        end
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
    assign o_bytes = r_bytes;

endmodule

`default_nettype wire

[hdl/lru_byte_budget_evictor.sv]
// ----------------------------------------------------------------------------
// lru_byte_budget_evictor
// LRU table with a byte budget: slot operations, restamping and eviction of
// the oldest unpinned, unheld entries while the resident total is over budget.
// ----------------------------------------------------------------------------
// Sequence: an accepted op runs EXEC, then FINAL, which loads the last result
//   onto o_out; insert, resize and trim pass through CHECK, and while over
//   budget each scan round (SCAN over all slots, DRAIN, RESOLVE) evicts one
//   entry and returns to CHECK, or ends in FINAL if no candidate is found.
// Throughput: one op at a time; o_out stalls hold RESOLVE and FINAL.
// Reset: table empty, total and access counter zero, budget 536870912.
`default_nettype none

`include "lru_byte_budget_evictor_assert.svh"

module lru_byte_budget_evictor #(
    parameter int SLOTS = lbbe_pkg::SLOTS_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    lbbe_in_if.sink        i_in,
    lbbe_cfg_if.sink       i_cfg,
    lbbe_out_if.source     o_out
);

    localparam int IW = $clog2(SLOTS);

    function automatic logic [lbbe_pkg::TOTAL_W-1:0] add_sat(
        input logic [lbbe_pkg::TOTAL_W-1:0] a,
        input logic [lbbe_pkg::BYTES_W-1:0] b
    );
        logic [lbbe_pkg::TOTAL_W:0] s;
        s = {1'b0, a} + {5'b0, b};
        return s[lbbe_pkg::TOTAL_W] ? lbbe_pkg::TOTAL_MAX : s[lbbe_pkg::TOTAL_W-1:0];
    endfunction

    function automatic logic [lbbe_pkg::TOTAL_W-1:0] sub_floor(
        input logic [lbbe_pkg::TOTAL_W-1:0] a,
        input logic [lbbe_pkg::BYTES_W-1:0] b
    );
        logic [lbbe_pkg::TOTAL_W:0] d;
        d = {1'b0, a} - {5'b0, b};
        return d[lbbe_pkg::TOTAL_W] ? '0 : d[lbbe_pkg::TOTAL_W-1:0];
    endfunction

    lbbe_pkg::t_state              r_state, n_state;
    lbbe_pkg::t_op                 r_op;
    logic [lbbe_pkg::SLOT_W-1:0]   r_slot;
    logic [lbbe_pkg::BYTES_W-1:0]  r_size;
    logic                          r_held;
    logic                          r_in_range;
    logic [IW-1:0]                 r_slot_idx;
    logic [lbbe_pkg::BYTES_W-1:0]  r_budget;
    logic [lbbe_pkg::TOTAL_W-1:0]  r_total;
    logic [lbbe_pkg::STAMP_W-1:0]  r_access;
    logic [SLOTS-1:0]              r_valid;
    logic [lbbe_pkg::EVCNT_W-1:0]  r_evict_cnt;
    logic [IW-1:0]                 r_scan_cnt;
    logic                          r_cmp_sample;
    logic [IW-1:0]                 r_cmp_idx;
    lbbe_pkg::t_result             r_pend;
    lbbe_pkg::t_result             r_out;
    logic                          r_out_last;
    logic                          r_out_valid;

    lbbe_pkg::t_entry              r_mem [SLOTS];
    lbbe_pkg::t_entry              r_rd;

    logic                          in_fire;
    logic                          in_range;
    logic [IW-1:0]                 in_idx;
    logic [IW-1:0]                 rd_addr;
    logic                          out_free;
    logic                          out_load;
    logic                          out_last;
    logic                          over_budget;
    logic                          scan_last;
    lbbe_pkg::t_scan_ctl           scan_ctl;
    logic                          found;
    logic [IW-1:0]                 found_idx;
    logic [lbbe_pkg::BYTES_W-1:0]  found_bytes;
    logic [lbbe_pkg::TOTAL_W-1:0]  evict_total;

    // EXEC datapath
    logic                          present;
    logic [lbbe_pkg::STAMP_W-1:0]  stamp_next;
    logic                          ex_take_stamp;
    logic                          ex_we;
    lbbe_pkg::t_entry              ex_entry;
    logic                          ex_set_valid;
    logic                          ex_clr_valid;
    logic [lbbe_pkg::TOTAL_W-1:0]  ex_total;
    logic                          ex_trim;
    lbbe_pkg::t_status             ex_status;

    assign in_fire     = i_in.valid && i_in.ready;
    assign in_range    = 32'(i_in.slot) < SLOTS;
    assign in_idx      = in_range ? IW'(i_in.slot) : '0;
    assign rd_addr     = (r_state == lbbe_pkg::S_IDLE) ? in_idx : r_scan_cnt;
    assign out_free    = !r_out_valid || o_out.ready;
    assign over_budget = (r_total > {4'b0, r_budget}) &&
                         (32'(r_evict_cnt) < lbbe_pkg::EVICT_CAP);
    assign scan_last   = (r_scan_cnt == IW'(SLOTS - 1));
    assign evict_total = sub_floor(r_total, found_bytes);

    assign i_in.ready  = (r_state == lbbe_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        present       = r_in_range && r_valid[r_slot_idx];
        stamp_next    = (r_access == lbbe_pkg::STAMP_MAX) ? r_access
                                                          : r_access + 1'b1;
        ex_take_stamp = 1'b0;
        ex_we         = 1'b0;
        ex_entry      = r_rd;
        ex_set_valid  = 1'b0;
        ex_clr_valid  = 1'b0;
        ex_total      = r_total;
        ex_trim       = 1'b0;
        ex_status     = lbbe_pkg::ST_OK;
        priority if (r_op == lbbe_pkg::OP_INSERT) begin
            priority if (r_size == '0) begin
                ex_status = lbbe_pkg::ST_ZERO_BYTES;
            end else if (!r_in_range) begin
                ex_status = lbbe_pkg::ST_ABSENT;
            end else if (present) begin
                ex_status = lbbe_pkg::ST_OCCUPIED;
            end else begin
                ex_entry.bytes = r_size;
                ex_entry.stamp = stamp_next;
                ex_entry.pins  = '0;
                ex_entry.held  = r_held;
                ex_we          = 1'b1;
                ex_take_stamp  = 1'b1;
                ex_set_valid   = 1'b1;
                ex_total       = add_sat(r_total, r_size);
                ex_trim        = 1'b1;
            end
        end else if (r_op == lbbe_pkg::OP_TRIM) begin
            ex_trim = 1'b1;
        end else if (!present) begin
            ex_status = lbbe_pkg::ST_ABSENT;
        end else begin
            unique case (r_op)
                lbbe_pkg::OP_TOUCH: begin
                    ex_entry.stamp = stamp_next;
                    ex_we          = 1'b1;
                    ex_take_stamp  = 1'b1;
                end
                lbbe_pkg::OP_RESIZE: begin
                    if (r_size == '0) begin
                        ex_status = lbbe_pkg::ST_ZERO_BYTES;
                    end else begin
                        ex_total       = add_sat(sub_floor(r_total, r_rd.bytes), r_size);
                        ex_entry.bytes = r_size;
                        ex_entry.stamp = stamp_next;
                        ex_we          = 1'b1;
                        ex_take_stamp  = 1'b1;
                        ex_trim        = 1'b1;
                    end
                end
                lbbe_pkg::OP_PIN: begin
                    if (r_rd.pins == lbbe_pkg::PIN_MAX) begin
                        ex_status = lbbe_pkg::ST_PIN_OVERFLOW;
                    end else begin
                        ex_entry.pins  = r_rd.pins + 1'b1;
                        ex_entry.stamp = stamp_next;
                        ex_we          = 1'b1;
                        ex_take_stamp  = 1'b1;
                    end
                end
                lbbe_pkg::OP_UNPIN: begin
                    if (r_rd.pins == '0) begin
                        ex_status = lbbe_pkg::ST_PIN_UNDERFLOW;
                    end else begin
                        ex_entry.pins = r_rd.pins - 1'b1;
                        ex_we         = 1'b1;
                    end
                end
                lbbe_pkg::OP_REMOVE: begin
                    ex_total     = sub_floor(r_total, r_rd.bytes);
                    ex_clr_valid = 1'b1;
                end
                lbbe_pkg::OP_SET_HELD: begin
                    ex_entry.held = r_held;
                    ex_we         = 1'b1;
                end
                default: begin
                    ex_status = lbbe_pkg::ST_OK;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lbbe_pkg::S_IDLE: begin
                if (in_fire) n_state = lbbe_pkg::S_EXEC;
            end
            lbbe_pkg::S_EXEC: begin
                n_state = ex_trim ? lbbe_pkg::S_CHECK : lbbe_pkg::S_FINAL;
            end
            lbbe_pkg::S_CHECK: begin
                n_state = over_budget ? lbbe_pkg::S_SCAN : lbbe_pkg::S_FINAL;
            end
            lbbe_pkg::S_SCAN: begin
                if (scan_last) n_state = lbbe_pkg::S_DRAIN;
            end
            lbbe_pkg::S_DRAIN: begin
                n_state = lbbe_pkg::S_RESOLVE;
            end
            lbbe_pkg::S_RESOLVE: begin
                if (!found) begin
                    n_state = lbbe_pkg::S_FINAL;
                end else if (out_free) begin
                    n_state = lbbe_pkg::S_CHECK;
                end
            end
            lbbe_pkg::S_FINAL: begin
                if (out_free) n_state = lbbe_pkg::S_IDLE;
            end
            default: n_state = lbbe_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        out_load        = 1'b0;
        out_last        = 1'b0;
        scan_ctl.clear  = 1'b0;
        scan_ctl.sample = r_cmp_sample;
        unique case (r_state)
            lbbe_pkg::S_CHECK: begin
                scan_ctl.clear = over_budget;
            end
            lbbe_pkg::S_RESOLVE: begin
                out_load = found && out_free;
            end
            lbbe_pkg::S_FINAL: begin
                out_load = out_free;
                out_last = 1'b1;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    lbbe_oldest #(
        .SLOTS (SLOTS)
    ) u_oldest (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (scan_ctl),
        .i_entry       (r_rd),
        .i_entry_valid (r_valid[r_cmp_idx]),
        .i_idx         (r_cmp_idx),
        .o_found       (found),
        .o_idx         (found_idx),
        .o_bytes       (found_bytes)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == lbbe_pkg::S_EXEC && ex_we) begin
            r_mem[r_slot_idx] <= ex_entry;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lbbe_pkg::S_IDLE;
            r_budget     <= lbbe_pkg::BUDGET_RESET;
            r_total      <= '0;
            r_access     <= '0;
            r_valid      <= '0;
            r_evict_cnt  <= '0;
            r_scan_cnt   <= '0;
            r_cmp_sample <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cmp_sample <= (r_state == lbbe_pkg::S_SCAN);
            if (i_cfg.valid && i_cfg.ready) begin
                r_budget <= i_cfg.byte_budget;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                lbbe_pkg::S_EXEC: begin
                    r_total     <= ex_total;
                    r_evict_cnt <= '0;
                    if (ex_take_stamp) r_access <= stamp_next;
                    if (ex_set_valid) r_valid[r_slot_idx] <= 1'b1;
                    if (ex_clr_valid) r_valid[r_slot_idx] <= 1'b0;
                end
                lbbe_pkg::S_CHECK: begin
                    r_scan_cnt <= '0;
                end
                lbbe_pkg::S_SCAN: begin
                    r_scan_cnt <= r_scan_cnt + 1'b1;
                end
                lbbe_pkg::S_RESOLVE: begin
                    if (out_load) begin
                        r_valid[found_idx] <= 1'b0;
                        r_total            <= evict_total;
                        r_evict_cnt        <= r_evict_cnt + 1'b1;
                    end
                end
                default: begin
                    r_scan_cnt <= r_scan_cnt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_scan_cnt;
        if (in_fire) begin
            r_op       <= lbbe_pkg::t_op'(i_in.op);
            r_slot     <= i_in.slot;
            r_size     <= i_in.byte_size;
            r_held     <= i_in.held_outside;
            r_in_range <= in_range;
            r_slot_idx <= in_idx;
        end
        if (r_state == lbbe_pkg::S_EXEC) begin
            r_pend.kind   <= lbbe_pkg::KIND_STATUS;
            r_pend.status <= ex_status;
            r_pend.slot   <= r_slot;
            r_pend.total  <= ex_total;
        end else if (r_state == lbbe_pkg::S_RESOLVE && out_load) begin
            r_pend.kind   <= lbbe_pkg::KIND_EVICT;
            r_pend.status <= lbbe_pkg::ST_OK;
            r_pend.slot   <= lbbe_pkg::SLOT_W'(found_idx);
            r_pend.total  <= evict_total;
        end
        if (out_load) begin
            r_out      <= r_pend;
            r_out_last <= out_last;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_out.kind;
    assign o_out.status         = r_out.status;
    assign o_out.result_slot    = r_out.slot;
    assign o_out.resident_total = r_out.total;
    assign o_out.last           = r_out_last;

    `LBBE_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, in_fire, r_state == lbbe_pkg::S_EXEC)
    `LBBE_ASSERT_NXT(a_last_idle, i_clk, i_rst_n, out_load && out_last, r_state == lbbe_pkg::S_IDLE)
    `LBBE_ASSERT_IMP(a_evict_cap, i_clk, i_rst_n, r_state == lbbe_pkg::S_CHECK, 32'(r_evict_cnt) <= lbbe_pkg::EVICT_CAP)
    `LBBE_ASSERT_IMP(a_found_valid, i_clk, i_rst_n, (r_state == lbbe_pkg::S_RESOLVE) && found, r_valid[found_idx])

endmodule

`default_nettype wire
